[rtl/core/fbdst_pkg.sv]
// Shared types and constants for the framebuffer dirty span tracker.
// Used by fbdst_span and by framebuffer_dirty_span_tracker_top; no dependencies.

package fbdst_pkg;

    // Default geometry and limits.
    localparam int PAGES_DEF   = 8;
    localparam int COLUMNS_DEF = 128;
    localparam int MAX_DESC    = 8;
    localparam int LEN_SAT     = 255;

    // Stream widths.
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;

    // Operation codes carried on the slave tuser.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Result kinds carried on the master tuser.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_SPAN = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FL_RD,
        ST_FL_EMIT
    } t_state;

    // Control group from the sequencer to the span table.
    typedef struct packed {
        logic wr_vld;
        logic rd_en;
        logic init_en;
        logic set_all;
        logic clr_all;
    } t_span_ctl;

endpackage

[rtl/core/fbdst_span.sv]
// Span table: per-page dirty flags and a min/max column memory with read-modify-write.
// Depends on fbdst_pkg for the control struct.

module fbdst_span
    import fbdst_pkg::*;
#(
    parameter int PAGES   = PAGES_DEF,
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PW      = (PAGES > 1) ? $clog2(PAGES) : 1,
    parameter int CW      = $clog2(COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_span_ctl        i_ctl,
    input  logic [PW-1:0]    i_wr_page,
    input  logic [CW-1:0]    i_wr_col,
    input  logic [PW-1:0]    i_rd_page,
    input  logic [PW-1:0]    i_init_page,
    output logic [CW-1:0]    o_rd_min,
    output logic [CW-1:0]    o_rd_max,
    output logic [PAGES-1:0] o_dirty
);

    localparam int EW = 2 * CW;

    logic [EW-1:0]    mem [PAGES];
    logic [EW-1:0]    r_rd_q;
    logic [PAGES-1:0] r_dirty;
    logic             r_pend;
    logic [PW-1:0]    r_page;
    logic [CW-1:0]    r_col;
    logic             r_wb_vld;
    logic [PW-1:0]    r_wb_page;
    logic [EW-1:0]    r_wb;
    logic [PW-1:0]    rd_addr;
    logic [EW-1:0]    old_ent;
    logic [CW-1:0]    old_min;
    logic [CW-1:0]    old_max;
    logic [CW-1:0]    n_min;
    logic [CW-1:0]    n_max;

    // A write request reads its page; otherwise the flush walk drives the address.
    assign rd_addr = i_ctl.wr_vld ? i_wr_page : i_rd_page;

    // Span memory: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_vld || i_ctl.rd_en) begin
            r_rd_q <= mem[rd_addr];
        end
        if (r_pend) begin
            mem[r_page] <= {n_min, n_max};
        end else if (i_ctl.init_en) begin
            mem[i_init_page] <= {CW'(0), CW'(COLUMNS - 1)};
        end
    end

    // The entry written back last cycle is not yet in the read data; forward it.
    always_comb begin
        old_ent = (r_wb_vld && (r_wb_page == r_page)) ? r_wb : r_rd_q;
        old_min = old_ent[EW-1:CW];
        old_max = old_ent[CW-1:0];
        if (!r_dirty[r_page]) begin
            n_min = r_col;
            n_max = r_col;
        end else begin
            n_min = (r_col < old_min) ? r_col : old_min;
            n_max = (r_col > old_max) ? r_col : old_max;
        end
    end

    // Modify stage and writeback bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_wb_vld <= 1'b0;
            r_dirty  <= '0;
        end else begin
            r_pend   <= i_ctl.wr_vld;
            r_wb_vld <= r_pend;
            if (i_ctl.clr_all) begin
                r_dirty <= '0;
            end else if (i_ctl.set_all) begin
                r_dirty <= '1;
            end else if (r_pend) begin
                r_dirty[r_page] <= 1'b1;
            end
        end
    end

    // Payload of the modify stage and the forwarding copy.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_vld) begin
            r_page <= i_wr_page;
            r_col  <= i_wr_col;
        end
        if (r_pend) begin
            r_wb_page <= r_page;
            r_wb      <= {n_min, n_max};
        end
    end

    assign o_rd_min = r_rd_q[EW-1:CW];
    assign o_rd_max = r_rd_q[CW-1:0];
    assign o_dirty  = r_dirty;

endmodule

[rtl/core/framebuffer_dirty_span_tracker_top.sv]
// Top level of the framebuffer dirty span tracker: frame store, sequencer, result register.
// Depends on fbdst_pkg and fbdst_span.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   tvalid/tready              tuser: opcode; tdata: page, column, write_byte
// m_axis    out  tvalid/tready, tlast       tuser: kind; tdata: page, column, length, byte
//
// A write is taken directly; a read passes through the store read, then the result register.
// A flush walks the pages through the span memory port, one page per cycle unless a
// descriptor waits on a stalled master side. A clear first zeroes the store at one entry per
// cycle and then flushes. After reset the same zeroing pass runs with s_axis_tready low.
// A result waiting on the master side does not hold off the next transfer unless a new
// result must be loaded.

module framebuffer_dirty_span_tracker_top
    import fbdst_pkg::*;
#(
    parameter int PAGES   = PAGES_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [2:0] page, [9:3] column, [17:10] write_byte, [23:18] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [2:0] out_page, [9:3] first_column, [17:10] span_length, [25:18] read_byte,
    // [31:26] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // [0] kind
    output logic                o_m_axis_tuser,
    output logic                o_m_axis_tlast
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int ND_W  = $clog2(MAX_DESC + 1);

    // Frame store and sequencer registers.
    logic [7:0]      mem [DEPTH];
    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_cnt;
    logic            r_is_clear;
    logic [PW-1:0]   r_pg;
    logic [ND_W-1:0] r_nd;

    // Read path.
    logic            r_rd_pend;
    logic [7:0]      r_rd_data;
    logic [2:0]      r_rd_page;
    logic [6:0]      r_rd_col;
    logic            r_rd_zero;

    // Result register.
    logic            r_out_vld;
    logic            r_out_kind;
    logic [2:0]      r_out_page;
    logic [6:0]      r_out_col;
    logic [7:0]      r_out_len;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    // Decoded input.
    t_op             in_op;
    logic [2:0]      in_page;
    logic [6:0]      in_col;
    logic [7:0]      in_byte;
    logic            in_inside;
    logic [AW-1:0]   in_addr;
    logic            s_ready;
    logic            s_acc;
    logic            slot_free;

    // Sequencer controls.
    logic            st_we;
    logic [AW-1:0]   st_waddr;
    logic [7:0]      st_wdata;
    logic            st_re;
    t_span_ctl       ctl;
    logic [PW-1:0]   rd_page;
    logic            load_rd;
    logic            load_span;
    logic            advance;
    logic            fl_done;
    logic            sw_done;
    logic            emit_want;
    logic            above;
    logic            desc_last;

    // Span table outputs.
    logic [CW-1:0]    sp_min;
    logic [CW-1:0]    sp_max;
    logic [PAGES-1:0] dirty;
    logic [CW:0]      len_raw;
    logic [7:0]       len_sat;

    // Input field unpacking and address range check.
    assign in_op     = t_op'(i_s_axis_tuser);
    assign in_page   = i_s_axis_tdata[2:0];
    assign in_col    = i_s_axis_tdata[9:3];
    assign in_byte   = i_s_axis_tdata[17:10];
    assign in_inside = (int'(in_page) < PAGES) && (int'(in_col) < COLUMNS);
    assign in_addr   = AW'(in_page) * AW'(COLUMNS) + AW'(in_col);

    assign s_ready         = (r_state == ST_IDLE) && !r_rd_pend;
    assign o_s_axis_tready = s_ready;
    assign s_acc           = i_s_axis_tvalid && s_ready;
    assign slot_free       = !r_out_vld || i_m_axis_tready;

    // Descriptor fields from the span memory read data.
    always_comb begin
        len_raw = {1'b0, sp_max} - {1'b0, sp_min} + (CW+1)'(1);
        if (sp_max < sp_min) begin
            len_raw = (CW+1)'(1);
        end
        len_sat = (int'(len_raw) > LEN_SAT) ? 8'(LEN_SAT) : 8'(len_raw);
    end

    // Is any page above the current one still dirty?
    always_comb begin
        above = 1'b0;
        for (int i = 0; i < PAGES; i++) begin
            if ((i > int'(r_pg)) && dirty[i]) begin
                above = 1'b1;
            end
        end
        desc_last = !above || (r_nd == ND_W'(MAX_DESC - 1));
        emit_want = dirty[r_pg] && (r_nd < ND_W'(MAX_DESC));
    end

    // Sequencer outputs.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = in_addr;
        st_wdata = in_byte;
        st_re    = 1'b0;
        ctl      = '0;
        rd_page  = r_pg;
        load_span = 1'b0;
        advance  = 1'b0;
        fl_done  = 1'b0;
        sw_done  = (r_cnt == AW'(DEPTH - 1));
        load_rd  = r_rd_pend && slot_free;
        case (r_state)
            ST_SWEEP: begin
                st_we       = 1'b1;
                st_waddr    = r_cnt;
                st_wdata    = '0;
                ctl.init_en = (int'(r_cnt) < PAGES);
                ctl.set_all = sw_done && r_is_clear;
            end
            ST_IDLE: begin
                if (s_acc && (in_op == OP_WRITE) && in_inside) begin
                    st_we      = 1'b1;
                    ctl.wr_vld = 1'b1;
                end
                if (s_acc && (in_op == OP_READ)) begin
                    st_re = 1'b1;
                end
            end
            ST_FL_RD: begin
                ctl.rd_en = 1'b1;
            end
            ST_FL_EMIT: begin
                load_span   = emit_want && slot_free;
                advance     = !emit_want || slot_free;
                fl_done     = advance && (r_pg == PW'(PAGES - 1));
                ctl.rd_en   = advance && !fl_done;
                rd_page     = r_pg + PW'(1);
                ctl.clr_all = fl_done;
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (sw_done) begin
                    n_state = r_is_clear ? ST_FL_RD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && (in_op == OP_FLUSH)) begin
                    n_state = ST_FL_RD;
                end else if (s_acc && (in_op == OP_CLEAR)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_FL_RD: begin
                n_state = ST_FL_EMIT;
            end
            ST_FL_EMIT: begin
                if (fl_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SWEEP;
            r_cnt      <= '0;
            r_is_clear <= 1'b0;
            r_pg       <= '0;
            r_nd       <= '0;
            r_rd_pend  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_cnt <= sw_done ? '0 : r_cnt + AW'(1);
                if (sw_done) begin
                    r_is_clear <= 1'b0;
                end
            end
            if (s_acc && (in_op == OP_CLEAR)) begin
                r_is_clear <= 1'b1;
            end
            if (n_state == ST_FL_RD) begin
                r_pg <= '0;
                r_nd <= '0;
            end else begin
                if (advance) begin
                    r_pg <= r_pg + PW'(1);
                end
                if (load_span) begin
                    r_nd <= r_nd + ND_W'(1);
                end
            end
            if (st_re) begin
                r_rd_pend <= 1'b1;
            end else if (load_rd) begin
                r_rd_pend <= 1'b0;
            end
            if (load_rd || load_span) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_rd_data <= mem[in_addr];
        end
    end

    // Read request payload and result register payload.
    always_ff @(posedge i_clk) begin
        if (st_re) begin
            r_rd_page <= in_page;
            r_rd_col  <= in_col;
            r_rd_zero <= !in_inside;
        end
        if (load_rd) begin
            r_out_kind <= KIND_READ;
            r_out_page <= r_rd_page;
            r_out_col  <= r_rd_col;
            r_out_len  <= '0;
            r_out_byte <= r_rd_zero ? 8'd0 : r_rd_data;
            r_out_last <= 1'b1;
        end else if (load_span) begin
            r_out_kind <= KIND_SPAN;
            r_out_page <= 3'(r_pg);
            r_out_col  <= 7'(sp_min);
            r_out_len  <= len_sat;
            r_out_byte <= '0;
            r_out_last <= desc_last;
        end
    end

    fbdst_span #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS),
        .PW      (PW),
        .CW      (CW)
    ) u_span (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_wr_page   (PW'(in_page)),
        .i_wr_col    (CW'(in_col)),
        .i_rd_page   (rd_page),
        .i_init_page (PW'(r_cnt)),
        .o_rd_min    (sp_min),
        .o_rd_max    (sp_max),
        .o_dirty     (dirty)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out_byte, r_out_len, r_out_col, r_out_page};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // A new result is only loaded when the result register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_rd || load_span) |-> slot_free)
        else $error("result loaded over an untaken result");

    // Read data and descriptors never compete for the result register.
    a_load_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load_rd && load_span))
        else $error("read result and descriptor loaded together");

    // An accepted read always leaves a pending read result behind.
    a_rd_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_op == OP_READ)) |=> r_rd_pend)
        else $error("read transfer lost");

    // A flush never emits more than the descriptor limit.
    a_nd_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FL_EMIT) |-> (r_nd <= ND_W'(MAX_DESC)))
        else $error("too many descriptors in one flush");

    // Leaving a flush leaves every page clean.
    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($past(r_state) == ST_FL_EMIT) && (r_state == ST_IDLE)) |-> (dirty == '0))
        else $error("dirty marks survived a flush");
`endif

endmodule
